### hw/rtl/lbbt_pkg.sv
package lbbt_pkg;

    localparam int unsigned CFG_W       = 11;
    localparam int unsigned OUT_COORD_W = 10;
    localparam int unsigned QUEUE_DEPTH = 2;

    typedef logic [OUT_COORD_W-1:0] coord_t;

    typedef enum logic [1:0] {
        CMD_VOXEL = 2'd0,
        CMD_READ  = 2'd1,
        CMD_START = 2'd2
    } cmd_t;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_IGNORED = 2'd1,
        ST_DONE    = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        REG_SIZE_Z    = 2'd0,
        REG_SIZE_Y    = 2'd1,
        REG_SIZE_X    = 2'd2,
        REG_MAX_LABEL = 2'd3
    } reg_idx_t;

    // work for the back part, decided at the front
    typedef enum logic [2:0] {
        OP_NONE      = 3'd0,
        OP_MARK      = 3'd1,
        OP_READ      = 3'd2,
        OP_READ_MISS = 3'd3,
        OP_START     = 3'd4
    } op_t;

    typedef struct packed {
        op_t     op;
        status_t status;
    } cls_t;

    typedef struct packed {
        logic [1:0]  command;
        logic [15:0] label;
    } req_t;

    typedef struct packed {
        logic [1:0] status;
        coord_t     z_min;
        coord_t     z_max;
        coord_t     y_min;
        coord_t     y_max;
        coord_t     x_min;
        coord_t     x_max;
    } rsp_t;

    typedef struct packed {
        logic [CFG_W-1:0] size_z;
        logic [CFG_W-1:0] size_y;
        logic [CFG_W-1:0] size_x;
        logic [CFG_W-1:0] max_label;
    } cfg_t;

    typedef struct packed {
        logic idle;
        logic busy;
        logic clearing;
    } bk_sts_t;

    // size register of zero or beyond the coordinate range acts as 2^cb
    function automatic logic [16:0] eff_size(input logic [CFG_W-1:0] v, input int unsigned cb);
        logic [16:0] lim;
        lim = 17'(1) << cb;
        if (v == '0 || 17'(v) > lim)
            eff_size = lim;
        else
            eff_size = 17'(v);
    endfunction

endpackage

### hw/rtl/label_bounding_box_tracker_top.sv
// Per-label 3D bounding box tracker.
// req channel: one item per handshake, command (voxel, read box, start volume)
// and label. Voxels come in raster order, x fastest; the block counts the
// position itself. rsp channel: one result item for every request item, in
// order: status and, for a read, the label's box (z, y, x min and max).
// The APB port sets the three volume sizes and the label limit; write it only
// while no item is in flight.
// A taken item passes through the queue, the box memory's registered read and
// the result register before its result shows on rsp_valid. The back end takes
// a new item only after the update and write-back of the last one.
// A start item also clears the seen marks, a sweep over the box memory, one
// entry per cycle.
// After reset the same sweep runs with req_stall high.
// When rsp_stall holds the result, the back end waits; up to two further
// items queue between the front and back before req_stall rises.
module label_bounding_box_tracker_top #(
    parameter int unsigned MAX_LABELS = 1024,
    parameter int unsigned COORD_BITS = 10
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           req_valid,
    output logic           req_stall,
    input  lbbt_pkg::req_t req,
    output logic           rsp_valid,
    input  logic           rsp_stall,
    output lbbt_pkg::rsp_t rsp,
    input  logic           psel,
    input  logic           penable,
    input  logic           pwrite,
    input  logic [3:0]     paddr,
    input  logic [31:0]    pwdata,
    output logic [31:0]    prdata,
    output logic           pready
);

    localparam int unsigned LBL_W = $clog2(MAX_LABELS);
    localparam int unsigned CB    = COORD_BITS;
    localparam int unsigned QW    = $bits(lbbt_pkg::cls_t) + LBL_W + 3 * CB;

    logic [lbbt_pkg::CFG_W-1:0] size_z_reg, size_y_reg, size_x_reg, max_label_reg;
    lbbt_pkg::cfg_t    cfg;
    lbbt_pkg::reg_idx_t reg_idx;

    logic              push;
    lbbt_pkg::cls_t    f_cls;
    logic [LBL_W-1:0]  f_idx;
    logic [CB-1:0]     f_pz, f_py, f_px;
    logic [QW-1:0]     q_wdata, q_rdata;
    logic              q_pop, q_full, q_empty;
    lbbt_pkg::cls_t    h_cls;
    logic [LBL_W-1:0]  h_idx;
    logic [CB-1:0]     h_pz, h_py, h_px;
    lbbt_pkg::bk_sts_t bk_sts;

    assign pready  = 1'b1;
    assign reg_idx = lbbt_pkg::reg_idx_t'(paddr[3:2]);
    assign cfg     = '{size_z: size_z_reg, size_y: size_y_reg,
                       size_x: size_x_reg, max_label: max_label_reg};

    always_comb
    begin
        unique case (reg_idx)
            lbbt_pkg::REG_SIZE_Z:    prdata = 32'(size_z_reg);
            lbbt_pkg::REG_SIZE_Y:    prdata = 32'(size_y_reg);
            lbbt_pkg::REG_SIZE_X:    prdata = 32'(size_x_reg);
            lbbt_pkg::REG_MAX_LABEL: prdata = 32'(max_label_reg);
            default:                 prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            size_z_reg    <= 11'd1;
            size_y_reg    <= 11'd1;
            size_x_reg    <= 11'd1;
            max_label_reg <= 11'd1024;
        end
        else if (psel && penable && pwrite)
        begin
            unique case (reg_idx)
                lbbt_pkg::REG_SIZE_Z:    size_z_reg    <= pwdata[lbbt_pkg::CFG_W-1:0];
                lbbt_pkg::REG_SIZE_Y:    size_y_reg    <= pwdata[lbbt_pkg::CFG_W-1:0];
                lbbt_pkg::REG_SIZE_X:    size_x_reg    <= pwdata[lbbt_pkg::CFG_W-1:0];
                lbbt_pkg::REG_MAX_LABEL: max_label_reg <= pwdata[lbbt_pkg::CFG_W-1:0];
                default:                 size_z_reg    <= size_z_reg;
            endcase
        end
    end

    // hold requests off while the queue is full or the seen marks are swept
    assign req_stall = q_full || bk_sts.clearing;

    lbbt_front #(
        .MAX_LABELS(MAX_LABELS),
        .COORD_BITS(COORD_BITS),
        .LBL_W     (LBL_W)
    ) u_front (
        .clk  (clk),
        .rst_n(rst_n),
        .cfg  (cfg),
        .valid(req_valid),
        .stall(req_stall),
        .item (req),
        .push (push),
        .cls  (f_cls),
        .idx  (f_idx),
        .pos_z(f_pz),
        .pos_y(f_py),
        .pos_x(f_px)
    );

    assign q_wdata = {f_cls, f_idx, f_pz, f_py, f_px};
    assign {h_cls, h_idx, h_pz, h_py, h_px} = q_rdata;

    lbbt_queue #(
        .WIDTH(QW)
    ) u_queue (
        .clk  (clk),
        .rst_n(rst_n),
        .push (push),
        .wdata(q_wdata),
        .pop  (q_pop),
        .rdata(q_rdata),
        .full (q_full),
        .empty(q_empty)
    );

    lbbt_back #(
        .MAX_LABELS(MAX_LABELS),
        .COORD_BITS(COORD_BITS),
        .LBL_W     (LBL_W)
    ) u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg),
        .q_empty  (q_empty),
        .q_cls    (h_cls),
        .q_idx    (h_idx),
        .q_pos_z  (h_pz),
        .q_pos_y  (h_py),
        .q_pos_x  (h_px),
        .q_pop    (q_pop),
        .rsp_valid(rsp_valid),
        .rsp_stall(rsp_stall),
        .rsp      (rsp),
        .sts      (bk_sts)
    );

`ifndef SYNTHESIS
    // a new result only comes out of the execute step
    a_rsp_from_exec: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rsp_valid) |-> $past(bk_sts.busy))
        else $error("result appeared without an execute step");

    // an idle back end never leaves a queued item waiting
    a_no_stuck_queue: assert property (@(posedge clk) disable iff (!rst_n)
        (bk_sts.idle && !q_empty) |=> !bk_sts.idle)
        else $error("back end idle with a queued item");

    // no request goes into the queue during the sweep
    a_no_push_in_sweep: assert property (@(posedge clk) disable iff (!rst_n)
        bk_sts.clearing |-> !push)
        else $error("item taken while seen marks are swept");
`endif

endmodule

### hw/rtl/lbbt_ram.sv
module lbbt_ram #(
    parameter int unsigned WIDTH = 61,
    parameter int unsigned DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

### hw/rtl/lbbt_queue.sv
module lbbt_queue #(
    parameter int unsigned WIDTH = 40
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] wdata,
    input  logic             pop,
    output logic [WIDTH-1:0] rdata,
    output logic             full,
    output logic             empty
);

    localparam int unsigned DEPTH = lbbt_pkg::QUEUE_DEPTH;
    localparam int unsigned PTR_W = $clog2(DEPTH);

    logic [WIDTH-1:0] slot_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [PTR_W:0]   count_reg, count_next;

    assign full  = (count_reg == (PTR_W+1)'(DEPTH));
    assign empty = (count_reg == '0);
    assign rdata = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg + (PTR_W+1)'(push) - (PTR_W+1)'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= wdata;
        end
    end

endmodule

### hw/rtl/lbbt_front.sv
module lbbt_front #(
    parameter int unsigned MAX_LABELS  = 1024,
    parameter int unsigned COORD_BITS  = 10,
    parameter int unsigned LBL_W       = 10
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  lbbt_pkg::cfg_t        cfg,
    input  logic                  valid,
    input  logic                  stall,
    input  lbbt_pkg::req_t        item,
    output logic                  push,
    output lbbt_pkg::cls_t        cls,
    output logic [LBL_W-1:0]      idx,
    output logic [COORD_BITS-1:0] pos_z,
    output logic [COORD_BITS-1:0] pos_y,
    output logic [COORD_BITS-1:0] pos_x
);

    localparam int unsigned SW = COORD_BITS + 1;

    logic [COORD_BITS-1:0] pos_z_reg, pos_z_next;
    logic [COORD_BITS-1:0] pos_y_reg, pos_y_next;
    logic [COORD_BITS-1:0] pos_x_reg, pos_x_next;
    logic [SW-1:0] ez, ey, ex;
    logic [SW-1:0] pz1, py1, px1;
    logic          wrap_z, wrap_y, wrap_x, done;
    logic          tracked;

    assign push  = valid && !stall;
    assign idx   = item.label[LBL_W-1:0];
    assign pos_z = pos_z_reg;
    assign pos_y = pos_y_reg;
    assign pos_x = pos_x_reg;

    always_comb
    begin
        ez = SW'(lbbt_pkg::eff_size(cfg.size_z, COORD_BITS));
        ey = SW'(lbbt_pkg::eff_size(cfg.size_y, COORD_BITS));
        ex = SW'(lbbt_pkg::eff_size(cfg.size_x, COORD_BITS));
        pz1 = {1'b0, pos_z_reg} + 1'b1;
        py1 = {1'b0, pos_y_reg} + 1'b1;
        px1 = {1'b0, pos_x_reg} + 1'b1;
        wrap_z = (pz1 >= ez);
        wrap_y = (py1 >= ey);
        wrap_x = (px1 >= ex);
        done   = wrap_x && wrap_y && wrap_z;
        tracked = (item.label != '0) && (item.label < 16'(cfg.max_label))
               && (17'(item.label) < 17'(MAX_LABELS));

        pos_z_next = pos_z_reg;
        pos_y_next = pos_y_reg;
        pos_x_next = pos_x_reg;
        cls.op     = lbbt_pkg::OP_NONE;
        cls.status = lbbt_pkg::ST_OK;

        unique case (item.command)
            lbbt_pkg::CMD_VOXEL:
            begin
                // ignored label wins over end of volume
                if (item.label == '0)
                begin
                    cls.status = done ? lbbt_pkg::ST_DONE : lbbt_pkg::ST_OK;
                end
                else if (tracked)
                begin
                    cls.op     = lbbt_pkg::OP_MARK;
                    cls.status = done ? lbbt_pkg::ST_DONE : lbbt_pkg::ST_OK;
                end
                else
                begin
                    cls.status = lbbt_pkg::ST_IGNORED;
                end
                pos_x_next = wrap_x ? '0 : px1[COORD_BITS-1:0];
                if (wrap_x)
                begin
                    pos_y_next = wrap_y ? '0 : py1[COORD_BITS-1:0];
                end
                if (wrap_x && wrap_y)
                begin
                    pos_z_next = wrap_z ? '0 : pz1[COORD_BITS-1:0];
                end
            end
            lbbt_pkg::CMD_READ:
            begin
                if (tracked)
                begin
                    cls.op = lbbt_pkg::OP_READ;
                end
                else
                begin
                    cls.op     = lbbt_pkg::OP_READ_MISS;
                    cls.status = lbbt_pkg::ST_IGNORED;
                end
            end
            lbbt_pkg::CMD_START:
            begin
                cls.op     = lbbt_pkg::OP_START;
                pos_z_next = '0;
                pos_y_next = '0;
                pos_x_next = '0;
            end
            default:
            begin
                cls.op = lbbt_pkg::OP_NONE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_z_reg <= '0;
            pos_y_reg <= '0;
            pos_x_reg <= '0;
        end
        else if (push)
        begin
            pos_z_reg <= pos_z_next;
            pos_y_reg <= pos_y_next;
            pos_x_reg <= pos_x_next;
        end
    end

endmodule

### hw/rtl/lbbt_back.sv
module lbbt_back #(
    parameter int unsigned MAX_LABELS = 1024,
    parameter int unsigned COORD_BITS = 10,
    parameter int unsigned LBL_W      = 10
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  lbbt_pkg::cfg_t        cfg,
    input  logic                  q_empty,
    input  lbbt_pkg::cls_t        q_cls,
    input  logic [LBL_W-1:0]      q_idx,
    input  logic [COORD_BITS-1:0] q_pos_z,
    input  logic [COORD_BITS-1:0] q_pos_y,
    input  logic [COORD_BITS-1:0] q_pos_x,
    output logic                  q_pop,
    output logic                  rsp_valid,
    input  logic                  rsp_stall,
    output lbbt_pkg::rsp_t        rsp,
    output lbbt_pkg::bk_sts_t     sts
);

    localparam int unsigned CB   = COORD_BITS;
    localparam int unsigned SW   = CB + 1;
    localparam int unsigned EW   = 6 * CB + 1;
    localparam logic [LBL_W-1:0] LAST = LBL_W'(MAX_LABELS - 1);

    typedef enum logic [1:0] {
        S_CLEAR,
        S_IDLE,
        S_EXEC
    } state_t;

    state_t                state_reg;
    logic [LBL_W-1:0]      clr_reg;
    lbbt_pkg::cls_t        cls_reg;
    logic [LBL_W-1:0]      idx_reg;
    logic [CB-1:0]         pz_reg, py_reg, px_reg;
    logic                  rsp_valid_reg;
    lbbt_pkg::rsp_t        rsp_reg;
    lbbt_pkg::rsp_t        res;

    logic                  ram_we;
    logic [LBL_W-1:0]      ram_waddr;
    logic [EW-1:0]         ram_wdata;
    logic [EW-1:0]         ram_rdata;
    logic                  slot_free;

    logic [SW-1:0] ez, ey, ex;
    logic [CB-1:0] ezm1, eym1, exm1;
    logic          seen;
    logic [CB-1:0] b_zmin, b_zmax, b_ymin, b_ymax, b_xmin, b_xmax;
    logic [CB-1:0] lo_z, hi_z, lo_y, hi_y, lo_x, hi_x;
    logic [CB-1:0] n_zmin, n_zmax, n_ymin, n_ymax, n_xmin, n_xmax;

    lbbt_ram #(
        .WIDTH(EW),
        .DEPTH(MAX_LABELS)
    ) u_box_ram (
        .clk  (clk),
        .we   (ram_we),
        .waddr(ram_waddr),
        .wdata(ram_wdata),
        .re   (q_pop),
        .raddr(q_idx),
        .rdata(ram_rdata)
    );

    assign q_pop        = (state_reg == S_IDLE) && !q_empty;
    assign slot_free    = !rsp_valid_reg || !rsp_stall;
    assign rsp_valid    = rsp_valid_reg;
    assign rsp          = rsp_reg;
    assign sts.idle     = (state_reg == S_IDLE);
    assign sts.busy     = (state_reg == S_EXEC);
    assign sts.clearing = (state_reg == S_CLEAR);

    always_comb
    begin
        ez   = SW'(lbbt_pkg::eff_size(cfg.size_z, CB));
        ey   = SW'(lbbt_pkg::eff_size(cfg.size_y, CB));
        ex   = SW'(lbbt_pkg::eff_size(cfg.size_x, CB));
        ezm1 = CB'(ez - 1'b1);
        eym1 = CB'(ey - 1'b1);
        exm1 = CB'(ex - 1'b1);

        seen   = ram_rdata[6*CB];
        b_zmin = ram_rdata[6*CB-1:5*CB];
        b_zmax = ram_rdata[5*CB-1:4*CB];
        b_ymin = ram_rdata[4*CB-1:3*CB];
        b_ymax = ram_rdata[3*CB-1:2*CB];
        b_xmin = ram_rdata[2*CB-1:CB];
        b_xmax = ram_rdata[CB-1:0];

        // a fresh box widens from (size-1, 0), which gives (min(pos, size-1), pos)
        lo_z = seen ? b_zmin : ezm1;
        hi_z = seen ? b_zmax : '0;
        lo_y = seen ? b_ymin : eym1;
        hi_y = seen ? b_ymax : '0;
        lo_x = seen ? b_xmin : exm1;
        hi_x = seen ? b_xmax : '0;

        n_zmin = (pz_reg < lo_z) ? pz_reg : lo_z;
        n_zmax = (pz_reg > hi_z) ? pz_reg : hi_z;
        n_ymin = (py_reg < lo_y) ? py_reg : lo_y;
        n_ymax = (py_reg > hi_y) ? py_reg : hi_y;
        n_xmin = (px_reg < lo_x) ? px_reg : lo_x;
        n_xmax = (px_reg > hi_x) ? px_reg : hi_x;

        res        = '0;
        res.status = cls_reg.status;
        unique case (cls_reg.op)
            lbbt_pkg::OP_READ:
            begin
                res.z_min = lbbt_pkg::coord_t'(seen ? b_zmin : ezm1);
                res.z_max = lbbt_pkg::coord_t'(seen ? b_zmax : '0);
                res.y_min = lbbt_pkg::coord_t'(seen ? b_ymin : eym1);
                res.y_max = lbbt_pkg::coord_t'(seen ? b_ymax : '0);
                res.x_min = lbbt_pkg::coord_t'(seen ? b_xmin : exm1);
                res.x_max = lbbt_pkg::coord_t'(seen ? b_xmax : '0);
            end
            lbbt_pkg::OP_READ_MISS:
            begin
                res.z_min = lbbt_pkg::coord_t'(ezm1);
                res.y_min = lbbt_pkg::coord_t'(eym1);
                res.x_min = lbbt_pkg::coord_t'(exm1);
            end
            lbbt_pkg::OP_NONE, lbbt_pkg::OP_MARK, lbbt_pkg::OP_START:
            begin
                res.z_min = '0;
            end
            default:
            begin
                res.z_min = '0;
            end
        endcase

        ram_we    = 1'b0;
        ram_waddr = idx_reg;
        ram_wdata = {1'b1, n_zmin, n_zmax, n_ymin, n_ymax, n_xmin, n_xmax};
        if (state_reg == S_CLEAR)
        begin
            ram_we    = 1'b1;
            ram_waddr = clr_reg;
            ram_wdata = '0;
        end
        else if (state_reg == S_EXEC && slot_free && cls_reg.op == lbbt_pkg::OP_MARK)
        begin
            ram_we = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            clr_reg       <= '0;
            cls_reg       <= '{op: lbbt_pkg::OP_NONE, status: lbbt_pkg::ST_OK};
            idx_reg       <= '0;
            pz_reg        <= '0;
            py_reg        <= '0;
            px_reg        <= '0;
            rsp_valid_reg <= 1'b0;
            rsp_reg       <= '0;
        end
        else
        begin
            if (state_reg == S_EXEC && slot_free)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (!rsp_stall)
            begin
                rsp_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_CLEAR:
                begin
                    if (clr_reg == LAST)
                    begin
                        state_reg <= S_IDLE;
                    end
                    else
                    begin
                        clr_reg <= clr_reg + 1'b1;
                    end
                end
                S_IDLE:
                begin
                    if (!q_empty)
                    begin
                        cls_reg   <= q_cls;
                        idx_reg   <= q_idx;
                        pz_reg    <= q_pos_z;
                        py_reg    <= q_pos_y;
                        px_reg    <= q_pos_x;
                        state_reg <= S_EXEC;
                    end
                end
                S_EXEC:
                begin
                    // hold the read data until the output slot frees up
                    if (slot_free)
                    begin
                        rsp_reg <= res;
                        if (cls_reg.op == lbbt_pkg::OP_START)
                        begin
                            clr_reg   <= '0;
                            state_reg <= S_CLEAR;
                        end
                        else
                        begin
                            state_reg <= S_IDLE;
                        end
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

endmodule

### sim/label_bounding_box_tracker_top_tb.sv
module label_bounding_box_tracker_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned MAX_LAB   = 1024;
    localparam int unsigned LONG_HOLD = 300;
    localparam int unsigned LIMIT     = 6000;
    localparam int unsigned AX_Z      = 0;
    localparam int unsigned AX_Y      = 1;
    localparam int unsigned AX_X      = 2;
    localparam logic [1:0]  CMD_UNUSED = 2'd3;

    class box_scoreboard;
        logic [lbbt_pkg::CFG_W-1:0] dim_reg [3];
        logic [lbbt_pkg::CFG_W-1:0] label_limit;
        bit                         seen [MAX_LAB];
        lbbt_pkg::coord_t           corner [MAX_LAB][6];
        int unsigned                pos [3];
        lbbt_pkg::rsp_t             boxes_due [$];
        int unsigned                errors;
        int unsigned                checked;
        int unsigned                finished;
        int unsigned                ignored;
        int unsigned                box_reads;

        function new();
            foreach (seen[i])
                seen[i] = 1'b0;
            foreach (pos[a])
            begin
                pos[a]     = 0;
                dim_reg[a] = 1;
            end
            label_limit = 1024;
            errors      = 0;
            checked     = 0;
            finished    = 0;
            ignored     = 0;
            box_reads   = 0;
        endfunction

        function void set_reg(lbbt_pkg::reg_idx_t idx, logic [lbbt_pkg::CFG_W-1:0] value);
            case (idx)
                lbbt_pkg::REG_SIZE_Z:    dim_reg[AX_Z] = value;
                lbbt_pkg::REG_SIZE_Y:    dim_reg[AX_Y] = value;
                lbbt_pkg::REG_SIZE_X:    dim_reg[AX_X] = value;
                lbbt_pkg::REG_MAX_LABEL: label_limit   = value;
                default:                 ;
            endcase
        endfunction

        // a size of zero or beyond the coordinate range spans the full range
        function int unsigned dim_of(int unsigned a);
            if (dim_reg[a] == 0 || dim_reg[a] > MAX_LAB)
                return MAX_LAB;
            return dim_reg[a];
        endfunction

        function bit is_tracked(int unsigned lab);
            return lab != 0 && lab < label_limit && lab < MAX_LAB;
        endfunction

        function void note_request(lbbt_pkg::req_t r);
            lbbt_pkg::rsp_t e;
            int unsigned    lab;
            int unsigned    d [3];
            bit             wrapped;
            e   = '0;
            lab = r.label;
            for (int a = 0; a < 3; a++)
                d[a] = dim_of(a);
            case (r.command)
                lbbt_pkg::CMD_VOXEL:
                begin
                    if (lab != 0)
                    begin
                        if (!is_tracked(lab))
                            e.status = lbbt_pkg::ST_IGNORED;
                        else if (!seen[lab])
                        begin
                            // counter may sit past a lowered size: clamp the min
                            for (int a = 0; a < 3; a++)
                            begin
                                corner[lab][2*a]   = lbbt_pkg::coord_t'(
                                    (pos[a] < d[a] - 1) ? pos[a] : d[a] - 1);
                                corner[lab][2*a+1] = lbbt_pkg::coord_t'(pos[a]);
                            end
                            seen[lab] = 1'b1;
                        end
                        else
                        begin
                            for (int a = 0; a < 3; a++)
                            begin
                                if (pos[a] < corner[lab][2*a])
                                    corner[lab][2*a] = lbbt_pkg::coord_t'(pos[a]);
                                if (pos[a] > corner[lab][2*a+1])
                                    corner[lab][2*a+1] = lbbt_pkg::coord_t'(pos[a]);
                            end
                        end
                    end
                    // advance x, then y on an x wrap, then z on a y wrap
                    wrapped = 1'b1;
                    for (int a = AX_X; a >= 0 && wrapped; a--)
                    begin
                        if (pos[a] + 1 >= d[a])
                            pos[a] = 0;
                        else
                        begin
                            pos[a]  = pos[a] + 1;
                            wrapped = 1'b0;
                        end
                    end
                    if (wrapped && e.status == lbbt_pkg::ST_OK)
                        e.status = lbbt_pkg::ST_DONE;
                end
                lbbt_pkg::CMD_READ:
                begin
                    box_reads++;
                    if (is_tracked(lab) && seen[lab])
                    begin
                        e.z_min = corner[lab][0];
                        e.z_max = corner[lab][1];
                        e.y_min = corner[lab][2];
                        e.y_max = corner[lab][3];
                        e.x_min = corner[lab][4];
                        e.x_max = corner[lab][5];
                    end
                    else
                    begin
                        e.z_min = lbbt_pkg::coord_t'(d[AX_Z] - 1);
                        e.y_min = lbbt_pkg::coord_t'(d[AX_Y] - 1);
                        e.x_min = lbbt_pkg::coord_t'(d[AX_X] - 1);
                        if (!is_tracked(lab))
                            e.status = lbbt_pkg::ST_IGNORED;
                    end
                end
                lbbt_pkg::CMD_START:
                begin
                    foreach (seen[i])
                        seen[i] = 1'b0;
                    foreach (pos[a])
                        pos[a] = 0;
                end
                default: ;
            endcase
            if (e.status == lbbt_pkg::ST_DONE)
                finished++;
            if (e.status == lbbt_pkg::ST_IGNORED)
                ignored++;
            boxes_due.push_back(e);
        endfunction

        function void compare_field(string field, logic [9:0] want, logic [9:0] got);
            if (want !== got)
            begin
                $display("%0t: %s mismatch, expected %0d, got %0d", $time, field, want, got);
                errors++;
            end
        endfunction

        function void check_result(lbbt_pkg::rsp_t got);
            lbbt_pkg::rsp_t want;
            if (boxes_due.size() == 0)
            begin
                $display("%0t: result %h arrived with nothing expected", $time, got);
                errors++;
                return;
            end
            want = boxes_due.pop_front();
            checked++;
            compare_field("status", 10'(want.status), 10'(got.status));
            compare_field("z_min", want.z_min, got.z_min);
            compare_field("z_max", want.z_max, got.z_max);
            compare_field("y_min", want.y_min, got.y_min);
            compare_field("y_max", want.y_max, got.y_max);
            compare_field("x_min", want.x_min, got.x_min);
            compare_field("x_max", want.x_max, got.x_max);
        endfunction
    endclass

    logic           clk;
    logic           rst_n;
    logic           req_valid;
    logic           req_stall;
    lbbt_pkg::req_t req;
    logic           rsp_valid;
    logic           rsp_stall;
    lbbt_pkg::rsp_t rsp;
    logic           psel;
    logic           penable;
    logic           pwrite;
    logic [3:0]     paddr;
    logic [31:0]    pwdata;
    logic [31:0]    prdata;
    logic           pready;

    box_scoreboard sb;
    bit            no_gaps;
    bit            long_hold;
    int unsigned   sent;
    int unsigned   settings;
    int unsigned   idle_cycles;

    label_bounding_box_tracker_top uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready)
    );

    always #6 clk = ~clk;

    always @(posedge clk)
    begin
        if (rsp_valid && !rsp_stall)
            sb.check_result(rsp);
        if (req_valid && !req_stall)
            sb.note_request(req);
    end

    initial
    begin
        idle_cycles = 0;
        while (idle_cycles < LIMIT)
        begin
            @(posedge clk);
            if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("%0t: no item moved for %0d cycles", $time, LIMIT);
        $display("Test completed with failures");
        $finish;
    end

    // result side: random stalls, plus one long hold-off on request
    initial
    begin
        int unsigned hold;
        rsp_stall = 1'b0;
        forever
        begin
            if (long_hold)
            begin
                rsp_stall <= 1'b1;
                repeat (LONG_HOLD) @(posedge clk);
                long_hold = 1'b0;
            end
            else
            begin
                hold = no_gaps ? 0 : $urandom_range(0, 8);
                if (hold != 0)
                begin
                    rsp_stall <= 1'b1;
                    repeat (hold) @(posedge clk);
                end
            end
            rsp_stall <= 1'b0;
            do @(posedge clk); while (!rsp_valid);
        end
    end

    function automatic lbbt_pkg::req_t mk_item(logic [1:0] command, logic [15:0] label);
        lbbt_pkg::req_t it;
        it.command = command;
        it.label   = label;
        return it;
    endfunction

    function automatic logic [15:0] pick_label();
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (roll < 12)
            return 16'd0;
        if (roll < 24)
            return 16'($urandom_range(0, 65535));
        if (roll < 34)
        begin
            case ($urandom_range(0, 4))
                0:       return 16'(sb.label_limit) - 16'd1;
                1:       return 16'(sb.label_limit);
                2:       return 16'(sb.label_limit) + 16'd1;
                3:       return 16'(MAX_LAB - 1);
                default: return 16'(MAX_LAB);
            endcase
        end
        // keep to a few labels so boxes grow and get read back
        return 16'($urandom_range(1, 12));
    endfunction

    function automatic lbbt_pkg::req_t random_item(int unsigned start_pct);
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (roll < start_pct)
            return mk_item(lbbt_pkg::CMD_START, 16'($urandom_range(0, 65535)));
        if (roll < start_pct + 4)
            return mk_item(CMD_UNUSED, 16'($urandom_range(0, 65535)));
        if (roll < start_pct + 24)
            return mk_item(lbbt_pkg::CMD_READ, pick_label());
        return mk_item(lbbt_pkg::CMD_VOXEL, pick_label());
    endfunction

    task automatic send_item(input lbbt_pkg::req_t item);
        int unsigned gap;
        gap = no_gaps ? 0 : $urandom_range(0, 8);
        if (gap != 0)
        begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_valid <= 1'b1;
        req       <= item;
        do @(posedge clk); while (req_stall);
        sent++;
    endtask

    task automatic run_random(input int unsigned count, input int unsigned start_pct);
        for (int unsigned i = 0; i < count; i++)
            send_item(random_item(start_pct));
    endtask

    task automatic write_reg(input lbbt_pkg::reg_idx_t idx,
                             input logic [lbbt_pkg::CFG_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= 32'(value);
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        sb.set_reg(idx, value);
    endtask

    task automatic configure(input logic [lbbt_pkg::CFG_W-1:0] z, y, x, limit);
        req_valid <= 1'b0;
        while (sb.boxes_due.size() != 0) @(posedge clk);
        // a start item keeps sweeping the marks after its result is out
        repeat (MAX_LAB + 16) @(posedge clk);
        write_reg(lbbt_pkg::REG_SIZE_Z, z);
        write_reg(lbbt_pkg::REG_SIZE_Y, y);
        write_reg(lbbt_pkg::REG_SIZE_X, x);
        write_reg(lbbt_pkg::REG_MAX_LABEL, limit);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        settings++;
    endtask

    initial
    begin
        clk       = 1'b0;
        rst_n     = 1'b0;
        req_valid = 1'b0;
        req       = '0;
        psel      = 1'b0;
        penable   = 1'b0;
        pwrite    = 1'b0;
        paddr     = '0;
        pwdata    = '0;
        no_gaps   = 1'b0;
        long_hold = 1'b0;
        sent      = 0;
        settings  = 1;
        sb        = new();
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        // reset register values
        run_random(40, 5);

        // six voxels per volume, labels 1 to 5 tracked
        configure(2, 1, 3, 6);
        send_item(mk_item(lbbt_pkg::CMD_START, 16'd0));
        send_item(mk_item(lbbt_pkg::CMD_READ, 16'd1));
        send_item(mk_item(lbbt_pkg::CMD_READ, 16'd0));
        send_item(mk_item(lbbt_pkg::CMD_READ, 16'd6));
        send_item(mk_item(lbbt_pkg::CMD_READ, 16'hFFFF));
        send_item(mk_item(CMD_UNUSED, 16'hFFFF));
        send_item(mk_item(lbbt_pkg::CMD_VOXEL, 16'd3));
        send_item(mk_item(lbbt_pkg::CMD_VOXEL, 16'd0));
        send_item(mk_item(lbbt_pkg::CMD_VOXEL, 16'd6));
        send_item(mk_item(lbbt_pkg::CMD_VOXEL, 16'd3));
        send_item(mk_item(lbbt_pkg::CMD_VOXEL, 16'hFFFF));
        send_item(mk_item(lbbt_pkg::CMD_VOXEL, 16'd5));
        send_item(mk_item(lbbt_pkg::CMD_VOXEL, 16'd3));
        send_item(mk_item(lbbt_pkg::CMD_VOXEL, 16'd2));
        send_item(mk_item(lbbt_pkg::CMD_VOXEL, 16'd1));
        send_item(mk_item(lbbt_pkg::CMD_VOXEL, 16'd1));
        send_item(mk_item(lbbt_pkg::CMD_VOXEL, 16'd5));
        // untracked label on the last voxel wins over the finish
        send_item(mk_item(lbbt_pkg::CMD_VOXEL, 16'd6));
        send_item(mk_item(lbbt_pkg::CMD_READ, 16'd3));
        send_item(mk_item(lbbt_pkg::CMD_READ, 16'd5));
        send_item(mk_item(lbbt_pkg::CMD_READ, 16'd1));
        send_item(mk_item(lbbt_pkg::CMD_READ, 16'd2));
        send_item(mk_item(lbbt_pkg::CMD_START, 16'hFFFF));
        send_item(mk_item(lbbt_pkg::CMD_READ, 16'd3));
        send_item(mk_item(lbbt_pkg::CMD_READ, 16'd5));

        configure(3, 4, 5, 32);
        run_random(150, 4);
        configure(1, 1, 1, 1);
        run_random(60, 5);
        // no start: leave the counters far along x
        configure(1024, 1024, 1024, 1024);
        run_random(100, 0);
        // shrink the sizes under the running counters
        configure(2, 3, 4, 1024);
        run_random(120, 3);
        configure(0, 2047, 0, 2047);
        run_random(80, 3);
        configure(4, 2, 2, 0);
        run_random(60, 5);

        configure(2, 2, 2, 10);
        no_gaps = 1'b1;
        run_random(150, 3);
        no_gaps = 1'b0;

        configure(3, 3, 3, 100);
        long_hold = 1'b1;
        run_random(200, 2);

        configure(5, 3, 7, 1024);
        run_random(150, 4);

        req_valid <= 1'b0;
        while (sb.boxes_due.size() != 0) @(posedge clk);
        repeat (16) @(posedge clk);

        $display("Sent %0d items under %0d register settings, %0d results checked.",
                 sent, settings, sb.checked);
        $display("Covered %0d finished volumes, %0d ignored labels, %0d box reads.",
                 sb.finished, sb.ignored, sb.box_reads);
        if (sb.errors == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
